/* hw/rtl/rgb_box_average_downscaler_unit_macros.svh */
// ---------------------------------------------------------------------------
// rgb_box_average_downscaler_unit_macros.svh
// Assertion macros used by the downscaler top level.
// ---------------------------------------------------------------------------
`ifndef RGB_BOX_AVERAGE_DOWNSCALER_UNIT_MACROS_SVH
`define RGB_BOX_AVERAGE_DOWNSCALER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rbad_pkg.sv */
// ---------------------------------------------------------------------------
// rbad_pkg
// Types and constants of the RGB box-average downscaler.
// ---------------------------------------------------------------------------
`default_nettype none

package rbad_pkg;

  localparam int MAX_WIDTH    = 8192;
  localparam int MAX_STEP     = 16;
  localparam int HEIGHT_LIMIT = 8192;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 14;
  localparam int STEP_W = 5;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BLK_W  = $clog2(MAX_STEP);
  localparam int CNT_W  = 2 * BLK_W + 1;
  localparam int SUM_W  = PIX_W + 2 * BLK_W;
  localparam int QCNT_W = $clog2(PIX_W);
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP   = 2'd2;

  // red in the lowest bits
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } rgb_sum_t;

  typedef struct packed {
    rgb_sum_t         sum;
    logic [CNT_W-1:0] count;
    logic             last;
  } div_job_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic first;
  } acc_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SUM
  } acc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/rbad_col_acc.sv */
// ---------------------------------------------------------------------------
// rbad_col_acc
// Column sum store: one RGB sum per output column, read, then added to the
// pixel and written back when the write is enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module rbad_col_acc (
  input  wire logic                      clk,
  input  wire rbad_pkg::acc_ctrl_t       ctrl,
  input  wire logic [rbad_pkg::COL_W-1:0] addr,
  input  wire rbad_pkg::rgb_pix_t        pixel,
  output rbad_pkg::rgb_sum_t             sum
);
  import rbad_pkg::*;

  rgb_sum_t         mem [MAX_WIDTH];
  rgb_sum_t         rd_data;
  logic [COL_W-1:0] addr_q;
  rgb_pix_t         pix_q;
  logic             first_q;

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[addr];
      addr_q  <= addr;
      pix_q   <= pixel;
      first_q <= ctrl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr_q] <= sum;
    end
  end

  // first pixel of a block restarts the sum
  always_comb begin
    if (first_q) begin
      sum.red   = SUM_W'(pix_q.red);
      sum.green = SUM_W'(pix_q.green);
      sum.blue  = SUM_W'(pix_q.blue);
    end else begin
      sum.red   = rd_data.red   + SUM_W'(pix_q.red);
      sum.green = rd_data.green + SUM_W'(pix_q.green);
      sum.blue  = rd_data.blue  + SUM_W'(pix_q.blue);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rbad_divider.sv */
// ---------------------------------------------------------------------------
// rbad_divider
// Restoring divider with the master stream's output register; one quotient
// bit per cycle for all three channels, the last bit waiting until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module rbad_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire rbad_pkg::div_job_t job,
  output logic                    ready,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [23:0]             m_axis_tdata,  // red, green, blue
  output logic                    m_axis_tlast   // frame_last
);
  import rbad_pkg::*;

  logic              running;
  logic [QCNT_W-1:0] step_cnt;
  rgb_sum_t          rem;
  logic [SUM_W-1:0]  dsh;
  rgb_pix_t          quo;
  logic              last_q;
  rgb_pix_t          out_pix;
  logic              out_last;

  rgb_sum_t          rem_next;
  rgb_pix_t          quo_next;
  logic              out_free;
  logic              go;

  // {quotient bit, new remainder}
  function automatic logic [SUM_W:0] div_step(logic [SUM_W-1:0] r, logic [SUM_W-1:0] d);
    logic [SUM_W:0] res;
    if (r >= d) res = {1'b1, r - d};
    else        res = {1'b0, r};
    return res;
  endfunction

  always_comb begin
    logic [SUM_W:0] sr, sg, sb;
    sr = div_step(rem.red,   dsh);
    sg = div_step(rem.green, dsh);
    sb = div_step(rem.blue,  dsh);
    rem_next.red   = sr[SUM_W-1:0];
    rem_next.green = sg[SUM_W-1:0];
    rem_next.blue  = sb[SUM_W-1:0];
    quo_next.red   = {quo.red[PIX_W-2:0],   sr[SUM_W]};
    quo_next.green = {quo.green[PIX_W-2:0], sg[SUM_W]};
    quo_next.blue  = {quo.blue[PIX_W-2:0],  sb[SUM_W]};
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  // final step waits for a free output register
  assign go       = running && ((step_cnt != '0) || out_free);
  assign ready    = !running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
      end else if (go && (step_cnt == '0)) begin
        running <= 1'b0;
      end
      if (go && (step_cnt == '0)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= job.sum;
      dsh      <= {job.count, (SUM_W - CNT_W)'(0)};
      quo      <= '0;
      last_q   <= job.last;
      step_cnt <= QCNT_W'(PIX_W - 1);
    end else if (go) begin
      rem      <= rem_next;
      dsh      <= dsh >> 1;
      quo      <= quo_next;
      step_cnt <= step_cnt - 1'b1;
      if (step_cnt == '0) begin
        out_pix  <= quo_next;
        out_last <= last_q;
      end
    end
  end

  assign m_axis_tdata = out_pix;
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

/* hw/rtl/rgb_box_average_downscaler_unit.sv */
// ---------------------------------------------------------------------------
// rgb_box_average_downscaler_unit
// Box-average RGB image downscaler, top level.
// ---------------------------------------------------------------------------
// Pixels come in raster order, one per input beat; each output beat is the
// truncated per-channel mean of one block of block_step x block_step pixels
// (edge blocks cut short and averaged over what they hold), sent when the
// block's last pixel arrives, with tlast on the frame's final output. For each
// pixel the column sum is read from the 8192-entry sum memory in ST_IDLE and
// written back in ST_SUM; no new pixel is taken until the write. A pixel that
// closes a block also hands its sums to the shared divider, which works out
// one quotient bit per step, so such a pixel waits in ST_SUM while the
// divider is still busy, and the divider stays busy while the output side holds
// off. A write to any of the three registers restarts the frame at the top left.
// Register indexes: 0 image_width, 1 image_height, 2 block_step.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb_box_average_downscaler_unit_macros.svh"

module rgb_box_average_downscaler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // red_out, green_out, blue_out
  output logic             m_axis_tlast,   // frame_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);
  import rbad_pkg::*;

  logic [DIM_W-1:0]  eff_width;
  logic [DIM_W-1:0]  eff_height;
  logic [STEP_W-1:0] eff_step;

  logic [COL_W-1:0]  pixel_column;
  logic [COL_W-1:0]  pixel_row;
  logic [BLK_W-1:0]  column_in_block;
  logic [BLK_W-1:0]  row_in_block;
  logic [COL_W-1:0]  output_column;

  acc_state_t        state, state_next;
  logic              blk_end;
  logic [CNT_W-1:0]  job_count;
  logic              job_last;

  logic              accept;
  logic              cfg_wr;
  logic              last_col, last_row, col_end, row_end;
  logic [2*STEP_W-1:0] count_full;
  acc_ctrl_t         acc_ctrl;
  rgb_sum_t          acc_sum;
  div_job_t          job;
  logic              div_start;
  logic              div_ready;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int lim);
    logic [DIM_W-1:0] r;
    if (v == '0)                       r = DIM_W'(1);
    else if (v > DIM_W'(lim))          r = DIM_W'(lim);
    else                               r = v;
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] clamp_step(logic [STEP_W-1:0] v);
    logic [STEP_W-1:0] r;
    if (v == '0)                       r = STEP_W'(1);
    else if (v > STEP_W'(MAX_STEP))    r = STEP_W'(MAX_STEP);
    else                               r = v;
    return r;
  endfunction

  assign cfg_ready     = 1'b1;
  assign cfg_wr        = cfg_valid && cfg_ready;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign last_col = ({1'b0, pixel_column} + DIM_W'(1)) >= eff_width;
  assign last_row = ({1'b0, pixel_row} + DIM_W'(1)) >= eff_height;
  assign col_end  = last_col || (({1'b0, column_in_block} + STEP_W'(1)) >= eff_step);
  assign row_end  = last_row || (({1'b0, row_in_block} + STEP_W'(1)) >= eff_step);
  assign count_full = (2*STEP_W)'({1'b0, column_in_block} + STEP_W'(1))
                    * (2*STEP_W)'({1'b0, row_in_block} + STEP_W'(1));

  // configuration; a write to a known register restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width       <= DIM_W'(1);
      eff_height      <= DIM_W'(1);
      eff_step        <= STEP_W'(1);
      pixel_column    <= '0;
      pixel_row       <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      output_column   <= '0;
    end else if (cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                            || cfg_index == REG_STEP)) begin
      unique case (cfg_index)
        REG_WIDTH:  eff_width  <= clamp_dim(cfg_data, MAX_WIDTH);
        REG_HEIGHT: eff_height <= clamp_dim(cfg_data, HEIGHT_LIMIT);
        default:    eff_step   <= clamp_step(cfg_data[STEP_W-1:0]);
      endcase
      pixel_column    <= '0;
      pixel_row       <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      output_column   <= '0;
    end else if (accept) begin
      if (last_col) begin
        pixel_column    <= '0;
        column_in_block <= '0;
        output_column   <= '0;
        if (last_row) begin
          pixel_row    <= '0;
          row_in_block <= '0;
        end else begin
          pixel_row    <= pixel_row + 1'b1;
          row_in_block <= row_end ? '0 : row_in_block + 1'b1;
        end
      end else begin
        pixel_column <= pixel_column + 1'b1;
        if (col_end) begin
          column_in_block <= '0;
          output_column   <= output_column + 1'b1;
        end else begin
          column_in_block <= column_in_block + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_end   <= col_end && row_end;
      job_count <= count_full[CNT_W-1:0];
      job_last  <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    acc_ctrl.rd_en = 1'b0;
    acc_ctrl.wr_en = 1'b0;
    acc_ctrl.first = (column_in_block == '0) && (row_in_block == '0);
    div_start      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        acc_ctrl.rd_en = accept;
        if (accept) state_next = ST_SUM;
      end
      ST_SUM: begin
        // block end holds here until the divider takes the sums
        if (!blk_end || div_ready) begin
          acc_ctrl.wr_en = 1'b1;
          div_start      = blk_end;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  rbad_col_acc u_col_acc (
    .clk   (clk),
    .ctrl  (acc_ctrl),
    .addr  (output_column),
    .pixel (rgb_pix_t'(s_axis_tdata)),
    .sum   (acc_sum)
  );

  assign job.sum   = acc_sum;
  assign job.count = job_count;
  assign job.last  = job_last;

  rbad_divider u_divider (
    .clk           (clk),
    .rst           (rst),
    .start         (div_start),
    .job           (job),
    .ready         (div_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `RBAD_ASSERT_IMP(a_col_in_image, 1'b1, {1'b0, pixel_column} < eff_width, "column outside image")
  `RBAD_ASSERT_IMP(a_cib_in_step, 1'b1, {1'b0, column_in_block} < eff_step, "column in block overrun")
  `RBAD_ASSERT_IMP(a_rib_in_step, 1'b1, {1'b0, row_in_block} < eff_step, "row in block overrun")
  `RBAD_ASSERT_IMP(a_start_when_free, div_start, div_ready, "divider started while busy")
  `RBAD_ASSERT_NXT(a_accept_to_sum, accept && !cfg_wr, state == ST_SUM, "accepted pixel not summed")

endmodule

`default_nettype wire
